FILE: sv/ptw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the four-level page table walker.
// No dependencies; every other file of the block uses this package.
package ptw_pkg;

   // Default physical address width; table bases and 4K frames use bits PHYS-1:12
   localparam int unsigned PHYS_ADDR_BITS_DEFAULT = 48;

   localparam int unsigned PAGE_SHIFT   = 12;
   localparam int unsigned VA_BITS      = 48;
   localparam int unsigned ADDR52_BITS  = 52;
   localparam int unsigned INDEX_BITS   = 9;
   localparam int unsigned ENTRY_BITS   = 64;
   localparam int unsigned CSR_IDX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS = 64;

   // Entry flag bits
   localparam int unsigned ENTRY_PRESENT_BIT = 0;
   localparam int unsigned ENTRY_LARGE_BIT   = 7;

   // Request kinds (req_type)
   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_RESPONSE = 1'b1;

   // Result kinds (out_kind)
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROOT_TABLE_BASE    = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIVE_LEVEL_ENABLED = 1'd1;

   // Walk levels: idle, then PML4, PDPT, PD, PT
   localparam logic [2:0] LVL_IDLE = 3'd0;
   localparam logic [2:0] LVL_PML4 = 3'd1;
   localparam logic [2:0] LVL_PDPT = 3'd2;
   localparam logic [2:0] LVL_PD   = 3'd3;
   localparam logic [2:0] LVL_PT   = 3'd4;

   typedef enum logic [1:0] {
      WALK_SUCCESS       = 2'd0,
      WALK_NOT_PRESENT   = 2'd1,
      WALK_INVALID_ROOT  = 2'd2,
      WALK_NOT_SUPPORTED = 2'd3
   } walk_status_type;

   typedef enum logic [1:0] {
      PAGE_NONE = 2'd0,
      PAGE_4K   = 2'd1,
      PAGE_2M   = 2'd2,
      PAGE_1G   = 2'd3
   } page_size_type;

   typedef struct packed {
      logic                  req_type;
      logic [63:0]           virt_addr;
      logic [ENTRY_BITS-1:0] entry_data;
      logic                  read_failed;
   } walk_item_type;

   typedef struct packed {
      logic                   out_kind;
      logic [ADDR52_BITS-1:0] read_addr;
      walk_status_type        walk_status;
      logic [ADDR52_BITS-1:0] phys_addr;
      page_size_type          page_size_code;
      logic [2:0]             depth_reached;
      logic [ENTRY_BITS-1:0]  final_entry;
   } walk_result_type;

endpackage

FILE: sv/ptw_walk_ctrl.sv
`timescale 1ns / 1ps
// Walk state and per-transaction step logic: start checks, entry decode,
// next read address and final translation. Depends on ptw_pkg.
module ptw_walk_ctrl #(
   parameter int unsigned PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  ptw_pkg::walk_item_type   item,
   input  logic [63:0]              root_table_base,
   input  logic                     five_level_enabled,
   output logic                     has_result,
   output ptw_pkg::walk_result_type result
);

   localparam int unsigned FRAME_BITS = PHYS_ADDR_BITS - ptw_pkg::PAGE_SHIFT;

   logic                                busy_ff, busy_in;
   logic [2:0]                          level_ff, level_in;
   logic [ptw_pkg::VA_BITS-1:0]         vaddr_ff, vaddr_in;
   logic [FRAME_BITS-1:0]               frame_ff, frame_in;
   logic [ptw_pkg::ENTRY_BITS-1:0]      entry;
   logic [ptw_pkg::INDEX_BITS-1:0]      idx;
   logic                                issue_read;

   // Decode one transaction against the current walk state
   always_comb begin
      entry      = item.read_failed ? '0 : item.entry_data;
      busy_in    = busy_ff;
      level_in   = level_ff;
      vaddr_in   = vaddr_ff;
      frame_in   = frame_ff;
      issue_read = 1'b0;
      has_result = 1'b0;
      result     = '0;

      if (item.req_type == ptw_pkg::REQ_START) begin
         // A start drops any walk in progress
         has_result = 1'b1;
         busy_in    = 1'b0;
         level_in   = ptw_pkg::LVL_IDLE;
         if (five_level_enabled) begin
            result.walk_status = ptw_pkg::WALK_NOT_SUPPORTED;
         end else if (root_table_base[ptw_pkg::PAGE_SHIFT-1:0] != '0 ||
                      root_table_base == '0) begin
            result.walk_status = ptw_pkg::WALK_INVALID_ROOT;
         end else begin
            busy_in    = 1'b1;
            level_in   = ptw_pkg::LVL_PML4;
            vaddr_in   = item.virt_addr[ptw_pkg::VA_BITS-1:0];
            frame_in   = root_table_base[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT];
            issue_read = 1'b1;
         end
      end else if (item.req_type == ptw_pkg::REQ_RESPONSE && busy_ff) begin
         has_result = 1'b1;
         busy_in    = 1'b0;
         level_in   = ptw_pkg::LVL_IDLE;
         result.depth_reached = level_ff;
         result.final_entry   = entry;
         if (!entry[ptw_pkg::ENTRY_PRESENT_BIT]) begin
            result.walk_status = ptw_pkg::WALK_NOT_PRESENT;
         end else if (level_ff == ptw_pkg::LVL_PDPT && entry[ptw_pkg::ENTRY_LARGE_BIT]) begin
            result.phys_addr      = {entry[51:30], vaddr_ff[29:0]};
            result.page_size_code = ptw_pkg::PAGE_1G;
         end else if (level_ff == ptw_pkg::LVL_PD && entry[ptw_pkg::ENTRY_LARGE_BIT]) begin
            result.phys_addr      = {entry[51:21], vaddr_ff[20:0]};
            result.page_size_code = ptw_pkg::PAGE_2M;
         end else if (level_ff == ptw_pkg::LVL_PT) begin
            result.phys_addr =
               (ptw_pkg::ADDR52_BITS'(entry[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT])
                << ptw_pkg::PAGE_SHIFT) |
               ptw_pkg::ADDR52_BITS'(vaddr_ff[ptw_pkg::PAGE_SHIFT-1:0]);
            result.page_size_code = ptw_pkg::PAGE_4K;
         end else begin
            // Descend one level
            busy_in    = 1'b1;
            level_in   = level_ff + 3'd1;
            frame_in   = entry[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT];
            issue_read = 1'b1;
            result.depth_reached = '0;
            result.final_entry   = '0;
         end
      end

      // Pick the table index for the level being read
      case (level_in)
         ptw_pkg::LVL_PML4: idx = vaddr_in[47:39];
         ptw_pkg::LVL_PDPT: idx = vaddr_in[38:30];
         ptw_pkg::LVL_PD:   idx = vaddr_in[29:21];
         default:           idx = vaddr_in[20:12];
      endcase

      result.out_kind = issue_read ? ptw_pkg::KIND_READ : ptw_pkg::KIND_DONE;
      if (issue_read) begin
         // Base is page aligned, so the add is a plain merge
         result.read_addr =
            (ptw_pkg::ADDR52_BITS'(frame_in) << ptw_pkg::PAGE_SHIFT) |
            (ptw_pkg::ADDR52_BITS'(idx) << 3);
      end
   end

   // Advance walk state on each processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= ptw_pkg::LVL_IDLE;
         vaddr_ff <= '0;
         frame_ff <= '0;
      end else if (step_en) begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         vaddr_ff <= vaddr_in;
         frame_ff <= frame_in;
      end
   end

endmodule

FILE: sv/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// Top level of the four-level page table walker: stream ports, configuration
// registers, input and result registers. Depends on ptw_pkg and ptw_walk_ctrl.
//
//   channel  direction  carries
//   req_*    in         start requests and memory entry responses
//   rsp_*    out        entry read requests and finished walk results
//   csr_*    in         root table base and five-level enable writes
//
// One transaction per cycle is accepted while rsp is not stalled; each goes from req
// to rsp via the input register, then one step of decode logic into the result register.
// Memory latency outside the block sets the time of a whole walk.
// Reset is synchronous and clears the walk state, valid flags and configuration registers.
// A stalled rsp side holds the result; the input register holds one more
// transaction, then req_tready drops.
module four_level_page_table_walker #(
   parameter int unsigned PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [127:0]                      req_tdata,  // virt_addr, entry_data
   input  logic [1:0]                        req_tuser,  // req_type, read_failed
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_addr, walk_status, phys_addr, page_size_code, depth_reached,
   // final_entry, one zero pad bit
   output logic [175:0]                      rsp_tdata,
   output logic [0:0]                        rsp_tuser,  // out_kind
   // Configuration
   input  logic                              csr_wr_en,
   input  logic [ptw_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ptw_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   ptw_pkg::walk_item_type   in_item_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   ptw_pkg::walk_result_type rsp_data_ff;
   logic [63:0]              root_ff;
   logic                     five_level_ff;
   logic                     advance;
   logic                     load_in;
   logic                     has_result;
   ptw_pkg::walk_result_type step_result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff       <= '0;
         five_level_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ptw_pkg::CSR_ROOT_TABLE_BASE:    root_ff       <= csr_wdata;
            ptw_pkg::CSR_FIVE_LEVEL_ENABLED: five_level_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Step the held transaction when the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign load_in    = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_item_ff.req_type    <= req_tuser[0];
         in_item_ff.read_failed <= req_tuser[1];
         in_item_ff.virt_addr   <= req_tdata[63:0];
         in_item_ff.entry_data  <= req_tdata[127:64];
      end
   end

   ptw_walk_ctrl #(
      .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
   ) u_walk_ctrl (
      .clock              (clock),
      .reset              (reset),
      .step_en            (advance),
      .item               (in_item_ff),
      .root_table_base    (root_ff),
      .five_level_enabled (five_level_ff),
      .has_result         (has_result),
      .result             (step_result)
   );

   // Result register: load a new result, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.out_kind;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.final_entry,
                        rsp_data_ff.depth_reached,
                        rsp_data_ff.page_size_code,
                        rsp_data_ff.phys_addr,
                        rsp_data_ff.walk_status,
                        rsp_data_ff.read_addr};

   // A held transaction stays put while the result side is stalled
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("input register changed while result side stalled");

   // Entry reads are 8-byte aligned and inside the physical address range
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_kind == ptw_pkg::KIND_READ) |->
         (rsp_data_ff.read_addr[2:0] == 3'd0 &&
          (rsp_data_ff.read_addr >> PHYS_ADDR_BITS) == '0))
      else $error("entry read address misaligned or out of range");

   // A successful walk names a page size and ends at level two or deeper
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.out_kind == ptw_pkg::KIND_DONE &&
       rsp_data_ff.walk_status == ptw_pkg::WALK_SUCCESS) |->
         (rsp_data_ff.page_size_code != ptw_pkg::PAGE_NONE &&
          rsp_data_ff.depth_reached >= ptw_pkg::LVL_PDPT))
      else $error("successful walk without page size or depth");

endmodule
